@@ hdl/gcdl_pkg.sv @@
// Package with widths shared by the list GCD block.
`timescale 1ns / 1ps
package gcdl_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PortWidth  = 32;
  localparam int unsigned WorkWidth  = (ValueWidth < PortWidth) ? ValueWidth : PortWidth;
  localparam int unsigned ShiftWidth = $clog2(WorkWidth + 1);

  typedef logic [WorkWidth-1:0]  work_t;
  typedef logic [ShiftWidth-1:0] shift_t;

endpackage

@@ hdl/gcd_of_number_list_top.sv @@
// Top level of the running GCD over lists of numbers.
// Operation: a first word is loaded straight into the running GCD; any other
// word starts the core on it and the running GCD, which takes one binary GCD
// step per cycle, all in the shared subtract and shift unit.
// Throughput: one word at a time, taken when idle with the output slot free.
// Reset clears the running GCD to zero and drops any pending result word.
`timescale 1ns / 1ps
module gcd_of_number_list_top
  import gcdl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PortWidth-1:0] value_i,
  input  logic                 first_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PortWidth-1:0] gcd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_e;

  state_e state_q;
  work_t  running_q;
  work_t  out_gcd_q;
  logic   out_valid_q;
  logic   last_q;

  work_t  value_w;
  work_t  core_res;
  logic   core_done;
  logic   core_start;
  logic   out_free;
  logic   in_accept;

  assign value_w    = value_i[WorkWidth-1:0];
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign core_start = in_accept && !first_i;

  gcdl_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .a_i     (value_w),
    .b_i     (running_q),
    .done_o  (core_done),
    .result_o(core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      out_gcd_q   <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (first_i) begin
              running_q <= value_w;
              if (last_i) begin
                out_valid_q <= 1'b1;
                out_gcd_q   <= value_w;
              end
            end else begin
              last_q  <= last_i;
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (core_done) begin
            running_q <= core_res;
            if (!last_q) begin
              state_q <= S_IDLE;
            end else if (out_free) begin
              out_valid_q <= 1'b1;
              out_gcd_q   <= core_res;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_gcd_q   <= running_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    gcd_o                = '0;
    gcd_o[WorkWidth-1:0] = out_gcd_q;
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/gcdl_core.sv @@
// Iterative binary GCD unit built around one shared subtract and shift step.
`timescale 1ns / 1ps
module gcdl_core
  import gcdl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  work_t a_i,
  input  work_t b_i,
  output logic  done_o,
  output work_t result_o
);

  typedef enum logic {
    S_IDLE,
    S_STEP
  } state_e;

  state_e state_q;
  work_t  a_q, b_q, res_q;
  shift_t k_q;
  logic   done_q;

  logic   a_ge_b;
  work_t  sub_x, sub_y, diff;

  always_comb begin
    a_ge_b = (a_q >= b_q);
    sub_x  = a_ge_b ? a_q : b_q;
    sub_y  = a_ge_b ? b_q : a_q;
    diff   = sub_x - sub_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (a_q == '0 || b_q == '0) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      if (start_i) begin
        a_q <= a_i;
        b_q <= b_i;
        k_q <= '0;
      end
    end else begin
      priority if (a_q == '0) begin
        res_q <= b_q << k_q;
      end else if (b_q == '0) begin
        res_q <= a_q << k_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + shift_t'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_ge_b) begin
        a_q <= diff;
      end else begin
        b_q <= diff;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
